@@ rtl/rqtwa_pkg.sv @@
// ----------------------------------------------------------------------------
// rqtwa_pkg: shared definitions
// Constants, codes and the command and status groups that pass between the
// controller and the datapath of the run-queue average block.
// ----------------------------------------------------------------------------
package rqtwa_pkg;

	localparam int NUM_CPUS_DEF   = 8;
	localparam int COUNT_BITS_DEF = 8;
	localparam int CPU_IDX_W      = 3;
	localparam int DIV_STEPS      = 128;

	localparam logic [6:0]  SCALE   = 7'd100;
	localparam logic [30:0] AVG_MAX = 31'h7FFF_FFFF;

	// Input command codes.
	localparam logic CMD_UPDATE = 1'b0;
	localparam logic CMD_POLL   = 1'b1;

	// One partial product: which operand pair and which 32-bit half.
	typedef enum logic [2:0] {
		MT_A_LO  = 3'd0,
		MT_A_HI  = 3'd1,
		MT_B_LO  = 3'd2,
		MT_B_HI  = 3'd3,
		MT_NA_LO = 3'd4,
		MT_NA_HI = 3'd5,
		MT_NB_LO = 3'd6,
		MT_NB_HI = 3'd7
	} mul_tag_t;

	typedef enum logic [1:0] {
		RES_ZERO,
		RES_FAULT,
		RES_QUOT
	} res_sel_t;

	typedef struct packed {
		logic                 load;
		logic                 upd_prep;
		logic                 upd_write;
		logic                 poll_prep;
		logic                 poll_start;
		logic                 cpu_prep;
		logic [CPU_IDX_W-1:0] ci;
		logic                 mul_en;
		mul_tag_t             mul_tag;
		logic                 div_step;
		logic                 res_load;
		res_sel_t             res_sel;
	} ctrl_cmd_t;

	typedef struct packed {
		logic upd_ok;
		logic span_zero;
		logic fault;
		logic out_busy;
	} ctrl_sts_t;

endpackage

@@ rtl/rqtwa_ctrl.sv @@
// ----------------------------------------------------------------------------
// rqtwa_ctrl: sequencing state machine
// Steps the datapath through an update or a poll and owns the step, CPU and
// division counters.
// ----------------------------------------------------------------------------
module rqtwa_ctrl #(
	parameter int NUM_CPUS = rqtwa_pkg::NUM_CPUS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic                  poll_req,
	output logic                  in_ready,
	input  rqtwa_pkg::ctrl_sts_t  sts,
	output rqtwa_pkg::ctrl_cmd_t  cmd
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_UPD_DT,
		S_UPD_CHK,
		S_UPD_MUL,
		S_UPD_DRAIN,
		S_UPD_WR,
		S_POLL_SPAN,
		S_POLL_CHK,
		S_POLL_DT,
		S_POLL_MUL,
		S_POLL_DRAIN,
		S_SCALE,
		S_SCALE_DRAIN,
		S_DIV,
		S_OUT
	} state_t;

	localparam logic [rqtwa_pkg::CPU_IDX_W-1:0] LAST_CPU =
		rqtwa_pkg::CPU_IDX_W'(NUM_CPUS - 1);
	localparam logic [rqtwa_pkg::CPU_IDX_W-1:0] CPU_ONE = rqtwa_pkg::CPU_IDX_W'(1);
	localparam logic [6:0] LAST_DIV = 7'(rqtwa_pkg::DIV_STEPS - 1);

	state_t                            state_q;
	logic [1:0]                        step_q;
	logic [rqtwa_pkg::CPU_IDX_W-1:0]   ci_q;
	logic [6:0]                        div_cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			step_q    <= '0;
			ci_q      <= '0;
			div_cnt_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= poll_req ? S_POLL_SPAN : S_UPD_DT;
					end
				end
				S_UPD_DT: state_q <= S_UPD_CHK;
				S_UPD_CHK: begin
					step_q  <= '0;
					state_q <= sts.upd_ok ? S_UPD_MUL : S_IDLE;
				end
				S_UPD_MUL: begin
					step_q <= step_q + 2'd1;
					if (step_q == 2'd3) begin
						state_q <= S_UPD_DRAIN;
					end
				end
				S_UPD_DRAIN: state_q <= S_UPD_WR;
				S_UPD_WR:    state_q <= S_IDLE;
				S_POLL_SPAN: state_q <= S_POLL_CHK;
				S_POLL_CHK: begin
					ci_q    <= '0;
					state_q <= sts.span_zero ? S_OUT : S_POLL_DT;
				end
				S_POLL_DT: begin
					step_q  <= '0;
					state_q <= S_POLL_MUL;
				end
				S_POLL_MUL: begin
					step_q <= step_q + 2'd1;
					if (step_q == 2'd3) begin
						state_q <= S_POLL_DRAIN;
					end
				end
				S_POLL_DRAIN: begin
					if (ci_q == LAST_CPU) begin
						step_q  <= '0;
						state_q <= S_SCALE;
					end else begin
						ci_q    <= ci_q + CPU_ONE;
						state_q <= S_POLL_DT;
					end
				end
				S_SCALE: begin
					step_q <= step_q + 2'd1;
					if (step_q == 2'd3) begin
						state_q <= S_SCALE_DRAIN;
					end
				end
				S_SCALE_DRAIN: begin
					div_cnt_q <= '0;
					state_q   <= sts.fault ? S_OUT : S_DIV;
				end
				S_DIV: begin
					div_cnt_q <= div_cnt_q + 7'd1;
					if (div_cnt_q == LAST_DIV) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (!sts.out_busy) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		cmd            = '0;
		cmd.load       = (state_q == S_IDLE) && in_valid;
		cmd.upd_prep   = (state_q == S_UPD_DT);
		cmd.upd_write  = (state_q == S_UPD_WR);
		cmd.poll_prep  = (state_q == S_POLL_SPAN);
		cmd.poll_start = (state_q == S_POLL_CHK) && !sts.span_zero;
		cmd.cpu_prep   = (state_q == S_POLL_DT);
		cmd.ci         = ci_q;
		cmd.mul_en     = (state_q == S_UPD_MUL) || (state_q == S_POLL_MUL) ||
		                 (state_q == S_SCALE);
		cmd.mul_tag    = rqtwa_pkg::mul_tag_t'({state_q == S_SCALE, step_q});
		cmd.div_step   = (state_q == S_DIV);
		cmd.res_load   = (state_q == S_OUT) && !sts.out_busy;
		if (sts.span_zero) begin
			cmd.res_sel = rqtwa_pkg::RES_ZERO;
		end else if (sts.fault) begin
			cmd.res_sel = rqtwa_pkg::RES_FAULT;
		end else begin
			cmd.res_sel = rqtwa_pkg::RES_QUOT;
		end
	end

endmodule

@@ rtl/rqtwa_dp.sv @@
// ----------------------------------------------------------------------------
// rqtwa_dp: datapath
// Per-CPU state, a shared 32-bit-slice multiplier with its accumulators, two
// bit-serial dividers and the result register.
// ----------------------------------------------------------------------------
module rqtwa_dp #(
	parameter int NUM_CPUS   = rqtwa_pkg::NUM_CPUS_DEF,
	parameter int COUNT_BITS = rqtwa_pkg::COUNT_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  rqtwa_pkg::ctrl_cmd_t  cmd,
	output rqtwa_pkg::ctrl_sts_t  sts,
	input  logic                  poll_req,
	input  logic [2:0]            cpu,
	input  logic [63:0]           time_now,
	input  logic [7:0]            runnable,
	input  logic                  inc,
	input  logic [7:0]            iowait_count,
	input  logic [63:0]           iowait_all,
	output logic [30:0]           avg_running,
	output logic [30:0]           avg_iowait,
	output logic                  clock_fault,
	output logic                  out_valid,
	input  logic                  out_ready
);

	localparam int CPU_W = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;
	localparam int CIN_W = (COUNT_BITS < 8) ? COUNT_BITS : 8;
	localparam int CNT_W = COUNT_BITS + 1;
	localparam int MA_W  = (CNT_W > 7) ? CNT_W : 7;
	localparam int P_W   = MA_W + 32;

	typedef struct packed {
		logic [127:0] num;
		logic [63:0]  rem;
		logic [30:0]  quo;
		logic         big;
	} div_state_t;

	// One restoring step: the remainder may briefly need 65 bits.
	function automatic div_state_t div_step(div_state_t s, logic [63:0] d);
		div_state_t  n;
		logic [64:0] rr;
		logic        ge;
		rr    = {s.rem, s.num[127]};
		ge    = (rr >= {1'b0, d});
		n.num = {s.num[126:0], 1'b0};
		n.rem = ge ? 64'(rr - {1'b0, d}) : rr[63:0];
		n.quo = {s.quo[29:0], ge};
		n.big = s.big | s.quo[30];
		return n;
	endfunction

	// Latched item
	logic              poll_q;
	logic [2:0]        cpu_q;
	logic [63:0]       now_q;
	logic [CIN_W-1:0]  nr_q;
	logic              inc_q;
	logic [CIN_W-1:0]  iow_q;
	logic [63:0]       iow_all_q;

	// Per-CPU state
	logic [63:0]       last_time_q [NUM_CPUS];
	logic [CNT_W-1:0]  count_q     [NUM_CPUS];
	logic [63:0]       run_sum_q   [NUM_CPUS];
	logic [63:0]       io_sum_q    [NUM_CPUS];
	logic [63:0]       last_poll_q;

	// Working registers
	logic [63:0]       span_q;
	logic [63:0]       dt_q;
	logic [63:0]       acc_a_q;
	logic [63:0]       acc_b_q;
	logic              fault_q;
	div_state_t        div_a_q;
	div_state_t        div_b_q;
	logic              mul_v_s1;
	rqtwa_pkg::mul_tag_t tag_s1;
	logic [P_W-1:0]    prod_s1;
	logic [30:0]       avg_run_q;
	logic [30:0]       avg_io_q;
	logic              fault_out_q;
	logic              out_valid_q;

	logic [CPU_W-1:0]  idx;
	logic [CPU_W-1:0]  ci;
	logic              in_range;
	logic [63:0]       dt_poll;
	logic [7:0]        lane8;
	logic [MA_W-1:0]   op_a;
	logic [31:0]       op_b;
	logic [CNT_W-1:0]  new_count;

	assign idx      = cpu_q[CPU_W-1:0];
	assign ci       = cmd.ci[CPU_W-1:0];
	assign in_range = ({1'b0, cpu_q} < 4'(NUM_CPUS));
	assign dt_poll  = now_q - last_time_q[ci];
	assign lane8    = iow_all_q[{cmd.ci, 3'b000} +: 8];

	always_comb begin
		if (inc_q) begin
			new_count = CNT_W'(nr_q) + CNT_W'(1);
		end else if (nr_q == '0) begin
			new_count = '0;
		end else begin
			new_count = CNT_W'(nr_q) - CNT_W'(1);
		end
	end

	always_comb begin
		unique case (cmd.mul_tag)
			rqtwa_pkg::MT_A_LO, rqtwa_pkg::MT_A_HI: begin
				op_a = poll_q ? MA_W'(count_q[ci]) : MA_W'(nr_q);
			end
			rqtwa_pkg::MT_B_LO, rqtwa_pkg::MT_B_HI: begin
				op_a = poll_q ? MA_W'(lane8[CIN_W-1:0]) : MA_W'(iow_q);
			end
			default: op_a = MA_W'(rqtwa_pkg::SCALE);
		endcase
		unique case (cmd.mul_tag)
			rqtwa_pkg::MT_A_LO, rqtwa_pkg::MT_B_LO: op_b = dt_q[31:0];
			rqtwa_pkg::MT_A_HI, rqtwa_pkg::MT_B_HI: op_b = dt_q[63:32];
			rqtwa_pkg::MT_NA_LO:                    op_b = acc_a_q[31:0];
			rqtwa_pkg::MT_NA_HI:                    op_b = acc_a_q[63:32];
			rqtwa_pkg::MT_NB_LO:                    op_b = acc_b_q[31:0];
			default:                                op_b = acc_b_q[63:32];
		endcase
	end

	// Control-side flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mul_v_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			mul_v_s1 <= cmd.mul_en;
			if (cmd.res_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Per-CPU state and the poll time stamp
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < NUM_CPUS; c++) begin
				last_time_q[c] <= '0;
				count_q[c]     <= '0;
				run_sum_q[c]   <= '0;
				io_sum_q[c]    <= '0;
			end
			last_poll_q <= '0;
		end else begin
			if (cmd.upd_write) begin
				last_time_q[idx] <= now_q;
				count_q[idx]     <= new_count;
				run_sum_q[idx]   <= acc_a_q;
				io_sum_q[idx]    <= acc_b_q;
			end
			if (cmd.cpu_prep) begin
				last_time_q[ci] <= now_q;
				run_sum_q[ci]   <= '0;
				io_sum_q[ci]    <= '0;
			end
			if (cmd.poll_start) begin
				last_poll_q <= now_q;
			end
		end
	end

	// Payload and working registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			poll_q    <= poll_req;
			cpu_q     <= cpu;
			now_q     <= time_now;
			nr_q      <= runnable[CIN_W-1:0];
			inc_q     <= inc;
			iow_q     <= iowait_count[CIN_W-1:0];
			iow_all_q <= iowait_all;
		end
		if (cmd.upd_prep) begin
			dt_q    <= now_q - last_time_q[idx];
			acc_a_q <= run_sum_q[idx];
			acc_b_q <= io_sum_q[idx];
		end
		if (cmd.poll_prep) begin
			span_q  <= now_q - last_poll_q;
			acc_a_q <= '0;
			acc_b_q <= '0;
			fault_q <= 1'b0;
			div_a_q <= '0;
			div_b_q <= '0;
		end
		if (cmd.poll_start) begin
			fault_q <= span_q[63];
		end
		if (cmd.cpu_prep) begin
			dt_q    <= dt_poll;
			fault_q <= fault_q | dt_poll[63];
			acc_a_q <= acc_a_q + run_sum_q[ci];
			acc_b_q <= acc_b_q + io_sum_q[ci];
		end
		prod_s1 <= P_W'(op_a) * P_W'(op_b);
		tag_s1  <= cmd.mul_tag;
		if (mul_v_s1) begin
			unique case (tag_s1)
				rqtwa_pkg::MT_A_LO:  acc_a_q <= acc_a_q + 64'(prod_s1);
				rqtwa_pkg::MT_A_HI:  acc_a_q <= acc_a_q + {prod_s1[31:0], 32'h0};
				rqtwa_pkg::MT_B_LO:  acc_b_q <= acc_b_q + 64'(prod_s1);
				rqtwa_pkg::MT_B_HI:  acc_b_q <= acc_b_q + {prod_s1[31:0], 32'h0};
				rqtwa_pkg::MT_NA_LO: div_a_q.num <= div_a_q.num + 128'(prod_s1);
				rqtwa_pkg::MT_NA_HI: div_a_q.num <= div_a_q.num + (128'(prod_s1) << 32);
				rqtwa_pkg::MT_NB_LO: div_b_q.num <= div_b_q.num + 128'(prod_s1);
				default:             div_b_q.num <= div_b_q.num + (128'(prod_s1) << 32);
			endcase
		end
		if (cmd.div_step) begin
			div_a_q <= div_step(div_a_q, span_q);
			div_b_q <= div_step(div_b_q, span_q);
		end
		if (cmd.res_load) begin
			unique case (cmd.res_sel)
				rqtwa_pkg::RES_QUOT: begin
					avg_run_q   <= div_a_q.big ? rqtwa_pkg::AVG_MAX : div_a_q.quo;
					avg_io_q    <= div_b_q.big ? rqtwa_pkg::AVG_MAX : div_b_q.quo;
					fault_out_q <= 1'b0;
				end
				rqtwa_pkg::RES_FAULT: begin
					avg_run_q   <= '0;
					avg_io_q    <= '0;
					fault_out_q <= 1'b1;
				end
				default: begin
					avg_run_q   <= '0;
					avg_io_q    <= '0;
					fault_out_q <= 1'b0;
				end
			endcase
		end
	end

	assign sts.upd_ok    = in_range && !dt_q[63];
	assign sts.span_zero = (span_q == '0);
	assign sts.fault     = fault_q;
	assign sts.out_busy  = out_valid_q && !out_ready;

	assign avg_running = avg_run_q;
	assign avg_iowait  = avg_io_q;
	assign clock_fault = fault_out_q;
	assign out_valid   = out_valid_q;

endmodule

@@ rtl/runqueue_time_weighted_average.sv @@
// ----------------------------------------------------------------------------
// runqueue_time_weighted_average: time-weighted run-queue length
// Top level joining the sequencing controller and the datapath.
// ----------------------------------------------------------------------------
// The block accepts one transaction at a time on the input channel and is
// busy until that transaction has been fully handled. A count update
// produces no result. In a poll with a non-zero span the shared multiplier
// folds in each CPU's open interval over four 32-bit partial products and
// scales the two totals by one hundred; unless a clock fault was seen, the
// two bit-serial dividers, working side by side, then each retire one
// quotient bit per cycle. The poll's result is held in an output register;
// the block goes on accepting transactions while it waits, but a following
// poll holds at its end, and keeps the input closed, until the earlier
// result has been taken.
// ----------------------------------------------------------------------------
module runqueue_time_weighted_average #(
	parameter int NUM_CPUS   = rqtwa_pkg::NUM_CPUS_DEF,
	parameter int COUNT_BITS = rqtwa_pkg::COUNT_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        cmd,
	input  logic [2:0]  cpu,
	input  logic [63:0] time_now,
	input  logic [7:0]  runnable,
	input  logic        inc,
	input  logic [7:0]  iowait_count,
	input  logic [63:0] iowait_all,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [30:0] avg_running,
	output logic [30:0] avg_iowait,
	output logic        clock_fault
);

	// The command group carries every strobe the datapath acts on; the status
	// group returns the few decisions the controller branches on.
	rqtwa_pkg::ctrl_cmd_t ctrl_cmd;
	rqtwa_pkg::ctrl_sts_t ctrl_sts;
	logic                 poll_req;

	assign poll_req = (cmd == rqtwa_pkg::CMD_POLL);

	rqtwa_ctrl #(
		.NUM_CPUS (NUM_CPUS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.poll_req (poll_req),
		.in_ready (in_ready),
		.sts      (ctrl_sts),
		.cmd      (ctrl_cmd)
	);

	// The datapath keeps every CPU's time stamp, count and sums, and is the
	// only place where the result register and its valid flag live.
	rqtwa_dp #(
		.NUM_CPUS   (NUM_CPUS),
		.COUNT_BITS (COUNT_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (ctrl_cmd),
		.sts          (ctrl_sts),
		.poll_req     (poll_req),
		.cpu          (cpu),
		.time_now     (time_now),
		.runnable     (runnable),
		.inc          (inc),
		.iowait_count (iowait_count),
		.iowait_all   (iowait_all),
		.avg_running  (avg_running),
		.avg_iowait   (avg_iowait),
		.clock_fault  (clock_fault),
		.out_valid    (out_valid),
		.out_ready    (out_ready)
	);

endmodule

@@ rtl/rqtwa_checker.sv @@
// ----------------------------------------------------------------------------
// rqtwa_sva: port-level checks
// Watches the top level's ports and is attached to it by a bind statement.
// ----------------------------------------------------------------------------
module rqtwa_sva (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [30:0] avg_running,
	input logic [30:0] avg_iowait,
	input logic        clock_fault
);

	// A stalled result stays offered.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result withdrawn before it was taken");

	// A faulted poll never reports averages.
	a_fault_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && clock_fault |-> (avg_running == '0) && (avg_iowait == '0))
		else $error("fault result carries non-zero averages");

	// An idle block with nothing offered invents no result.
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid && in_ready && !in_valid |=> !out_valid)
		else $error("result appeared without a transaction");

	// Accepting a transaction drops ready in the next cycle.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("ready stayed high after a transaction was accepted");

endmodule

bind runqueue_time_weighted_average rqtwa_sva u_rqtwa_sva (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_ready    (in_ready),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.avg_running (avg_running),
	.avg_iowait  (avg_iowait),
	.clock_fault (clock_fault)
);
